/* hw/rtl/psrc_pkg.sv */
package psrc_pkg;

	localparam int MAX_PORTS_DEF = 1024;
	localparam int NUM_SLOTS_DEF = 6;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 40;
	localparam int PORT_OUT_W = 11;

	localparam logic [15:0] PORT_BASE_RST = 16'd20000;
	localparam logic [39:0] KIND_CODES_RST = 40'h05_0403_0201;
	localparam logic [17:0] SLOT_MAP_RST = 18'h3FFFF;

	localparam logic [7:0] PROTO_ICMP = 8'd1;
	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;

	localparam logic [7:0] ICMP_UNREACH = 8'd3;
	localparam logic [7:0] UNR_HOST = 8'd1;
	localparam logic [7:0] UNR_PROTO = 8'd2;
	localparam logic [7:0] UNR_PORT = 8'd3;
	localparam logic [7:0] UNR_NET_PROHIB = 8'd9;
	localparam logic [7:0] UNR_HOST_PROHIB = 8'd10;
	localparam logic [7:0] UNR_ADMIN_PROHIB = 8'd13;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TARGET_ADDR = 3'd0,
		REG_OS_DETECT = 3'd1,
		REG_PORT_BASE = 3'd2,
		REG_KIND_CODES = 3'd3,
		REG_SLOT_MAP = 3'd4
	} cfg_reg_t;

	typedef enum logic [2:0] {
		KIND_NONE = 3'd0,
		KIND_SYN = 3'd1,
		KIND_ACK = 3'd2,
		KIND_FIN = 3'd3,
		KIND_NULL = 3'd4,
		KIND_XMAS = 3'd5,
		KIND_UDP = 3'd6
	} kind_t;

	typedef enum logic [2:0] {
		ST_UNSET = 3'd0,
		ST_OPEN = 3'd1,
		ST_CLOSED = 3'd2,
		ST_FILTERED = 3'd3,
		ST_UNFILTERED = 3'd4,
		ST_OPEN_OR_FILTERED = 3'd5
	} status_t;

	typedef struct packed {
		logic [31:0] target_address;
		logic os_detect_enable;
		logic [15:0] probe_port_base;
		logic [39:0] kind_codes;
		logic [17:0] slot_map;
	} cfg_t;

	typedef struct packed {
		logic [31:0] source_address;
		logic [7:0] ip_protocol;
		logic [7:0] ip_ttl;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [2:0] tcp_flags;
		logic [7:0] icmp_type;
		logic [7:0] icmp_code;
		logic [7:0] inner_protocol;
		logic [15:0] inner_src_port;
		logic [15:0] inner_dst_port;
	} pkt_t;

	// decode result handed from the lookup stage to the write stage
	typedef struct packed {
		logic accepted;
		logic tcp;
		logic have;
		logic latch;
		kind_t kind;
		logic [2:0] slot;
		status_t stat;
		logic [15:0] port;
		logic [2:0] flags;
		logic [7:0] ttl;
	} dec_t;

endpackage

/* hw/rtl/psrc_decode.sv */
module psrc_decode #(
	parameter int MAX_PORTS = 1024,
	parameter int NUM_SLOTS = 6
) (
	input psrc_pkg::pkt_t pkt,
	input psrc_pkg::cfg_t cfg,
	input psrc_pkg::kind_t cur_kind,
	input logic [2:0] cur_slot,
	output psrc_pkg::dec_t dec
);
	import psrc_pkg::*;

	function automatic logic port_ok(input logic [15:0] p);
		return (p != 16'd0) && (p <= 16'(MAX_PORTS));
	endfunction

	// lowest kind wins when offsets collide
	function automatic kind_t find_kind(input logic [15:0] p, input logic [15:0] base,
			input logic [39:0] codes);
		kind_t r;
		r = KIND_NONE;
		for (int k = 4; k >= 0; k--) begin
			if (p == base + 16'(codes[8*k +: 8]))
				r = kind_t'(3'(k + 1));
		end
		return r;
	endfunction

	function automatic logic [2:0] pick_slot(input kind_t k, input logic [17:0] smap,
			input logic [2:0] cur);
		logic [2:0] idx;
		logic [2:0] s;
		idx = 3'(k) - 3'd1;
		s = smap[5'(idx) * 5'd3 +: 3];
		if (k == KIND_NONE || 3'(k) == 3'd7 || {1'b0, s} >= 4'(NUM_SLOTS))
			return cur;
		return s;
	endfunction

	logic [15:0] look_port;
	kind_t found;
	logic code_filt;

	assign look_port = (pkt.ip_protocol == PROTO_ICMP) ? pkt.inner_src_port : pkt.dst_port;
	assign found = find_kind(look_port, cfg.probe_port_base, cfg.kind_codes);
	assign code_filt = pkt.icmp_code == UNR_HOST || pkt.icmp_code == UNR_PROTO
		|| pkt.icmp_code == UNR_NET_PROHIB || pkt.icmp_code == UNR_HOST_PROHIB
		|| pkt.icmp_code == UNR_ADMIN_PROHIB;

	always_comb begin
		dec = '0;
		dec.kind = cur_kind;
		dec.slot = cur_slot;
		dec.stat = ST_UNSET;
		dec.flags = pkt.tcp_flags;
		dec.ttl = pkt.ip_ttl;
		if (pkt.source_address == cfg.target_address) begin
			dec.accepted = 1'b1;
			priority if (pkt.ip_protocol == PROTO_ICMP) begin
				dec.port = pkt.inner_dst_port;
				if (pkt.inner_protocol == PROTO_TCP) begin
					if (found != KIND_NONE) begin
						dec.kind = found;
						dec.slot = pick_slot(found, cfg.slot_map, cur_slot);
					end
					if (pkt.icmp_type == ICMP_UNREACH
							&& (code_filt || pkt.icmp_code == UNR_PORT)) begin
						dec.have = 1'b1;
						dec.stat = ST_FILTERED;
					end
				end else begin
					dec.kind = KIND_UDP;
					dec.slot = pick_slot(KIND_UDP, cfg.slot_map, cur_slot);
					if (pkt.icmp_type == ICMP_UNREACH) begin
						if (pkt.icmp_code == UNR_PORT) begin
							dec.have = 1'b1;
							dec.stat = ST_CLOSED;
						end else if (code_filt) begin
							dec.have = 1'b1;
							dec.stat = ST_FILTERED;
						end
					end
				end
				if (!port_ok(pkt.inner_dst_port))
					dec.have = 1'b0;
			end else if (pkt.ip_protocol == PROTO_TCP) begin
				dec.port = pkt.src_port;
				if (port_ok(pkt.src_port)) begin
					dec.tcp = 1'b1;
					if (found != KIND_NONE) begin
						dec.kind = found;
						dec.slot = pick_slot(found, cfg.slot_map, cur_slot);
					end
				end
			end else if (pkt.ip_protocol == PROTO_UDP) begin
				dec.port = pkt.src_port;
				dec.kind = KIND_UDP;
				dec.slot = pick_slot(KIND_UDP, cfg.slot_map, cur_slot);
				if (port_ok(pkt.src_port)) begin
					dec.have = 1'b1;
					dec.latch = 1'b1;
					dec.stat = ST_OPEN;
				end
			end else begin
				dec.have = 1'b0;
			end
		end
	end

endmodule

/* hw/rtl/psrc_status_mem.sv */
module psrc_status_mem #(
	parameter int DEPTH = 6144,
	parameter int ADDR_W = 13
) (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input logic [ADDR_W-1:0] wr_addr,
	input psrc_pkg::status_t wr_data,
	input logic rd_en,
	input logic [ADDR_W-1:0] rd_addr,
	output psrc_pkg::status_t rd_data,
	output logic ready
);
	import psrc_pkg::*;

	status_t mem [DEPTH];
	logic clearing_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic we;
	logic [ADDR_W-1:0] waddr;
	status_t wdata;

	assign ready = !clearing_q;
	assign we = clearing_q || wr_en;
	assign waddr = clearing_q ? clr_addr_q : wr_addr;
	assign wdata = clearing_q ? ST_UNSET : wr_data;

	// one entry per cycle swept to unset after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			if (clr_addr_q == ADDR_W'(DEPTH - 1))
				clearing_q <= 1'b0;
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (rd_en)
			rd_data <= mem[rd_addr];
	end

endmodule

/* hw/rtl/port_scan_response_classifier_core.sv */
// Port scan reply classifier. An item is taken when start is high and busy is low and
// then passes through the accept edge, the kind lookup with the port status table read
// for tcp replies, and the step that writes the table back and presents the result. The
// result stands on the outputs for exactly one cycle with done high; it cannot be held
// off. busy drops in that same cycle, so the next item may start then; a new item is not
// taken until the previous one has presented its result, so the status table read and
// write of one item never overlap those of another. After reset busy stays high while
// the NUM_SLOTS * MAX_PORTS table entries (6144 by default) are swept to unset;
// configuration writes are taken throughout.
module port_scan_response_classifier_core #(
	parameter int MAX_PORTS = psrc_pkg::MAX_PORTS_DEF,
	parameter int NUM_SLOTS = psrc_pkg::NUM_SLOTS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic [psrc_pkg::CFG_IDX_W-1:0] cfg_idx,
	input logic [psrc_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input logic start,
	output logic busy,
	input logic [31:0] source_address,
	input logic [7:0] ip_protocol,
	input logic [7:0] ip_ttl,
	input logic [15:0] src_port,
	input logic [15:0] dst_port,
	input logic [2:0] tcp_flags,
	input logic [7:0] icmp_type,
	input logic [7:0] icmp_code,
	input logic [7:0] inner_protocol,
	input logic [15:0] inner_src_port,
	input logic [15:0] inner_dst_port,
	output logic done,
	output logic accepted,
	output logic wrote,
	output logic [2:0] slot,
	output logic [psrc_pkg::PORT_OUT_W-1:0] port,
	output logic [2:0] new_status,
	output logic [7:0] captured_ttl
);
	import psrc_pkg::*;

	localparam int DEPTH = NUM_SLOTS * MAX_PORTS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOK,
		S_WRITE
	} state_t;

	state_t state_q;
	cfg_t cfg_q;
	pkt_t pkt_s1;
	dec_t dec;
	dec_t dec_s2;
	kind_t kind_q;
	logic [2:0] slot_q;
	logic [7:0] latched_q;
	logic [ADDR_W-1:0] addr;
	logic [ADDR_W-1:0] addr_s2;
	logic mem_ready;
	status_t rd_data;
	logic take;
	logic have_w;
	logic latch_w;
	status_t stat_w;
	logic old_final;
	logic [7:0] ttl_next;

	assign busy = (state_q != S_IDLE) || !mem_ready;
	assign take = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_address <= '0;
			cfg_q.os_detect_enable <= 1'b0;
			cfg_q.probe_port_base <= PORT_BASE_RST;
			cfg_q.kind_codes <= KIND_CODES_RST;
			cfg_q.slot_map <= SLOT_MAP_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_idx)
				REG_TARGET_ADDR: cfg_q.target_address <= cfg_wdata[31:0];
				REG_OS_DETECT: cfg_q.os_detect_enable <= cfg_wdata[0];
				REG_PORT_BASE: cfg_q.probe_port_base <= cfg_wdata[15:0];
				REG_KIND_CODES: cfg_q.kind_codes <= cfg_wdata[39:0];
				REG_SLOT_MAP: cfg_q.slot_map <= cfg_wdata[17:0];
				default: ;
			endcase
		end
	end

	psrc_decode #(
		.MAX_PORTS(MAX_PORTS),
		.NUM_SLOTS(NUM_SLOTS)
	) u_decode (
		.pkt(pkt_s1),
		.cfg(cfg_q),
		.cur_kind(kind_q),
		.cur_slot(slot_q),
		.dec(dec)
	);

	assign addr = ADDR_W'(dec.slot) * ADDR_W'(MAX_PORTS) + ADDR_W'(dec.port - 16'd1);

	psrc_status_mem #(
		.DEPTH(DEPTH),
		.ADDR_W(ADDR_W)
	) u_mem (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(state_q == S_WRITE && have_w),
		.wr_addr(addr_s2),
		.wr_data(stat_w),
		.rd_en(state_q == S_LOOK && dec.tcp),
		.rd_addr(addr),
		.rd_data(rd_data),
		.ready(mem_ready)
	);

	// tcp replies never overwrite a final state
	assign old_final = rd_data == ST_OPEN || rd_data == ST_CLOSED || rd_data == ST_UNFILTERED;

	always_comb begin
		have_w = dec_s2.have;
		latch_w = dec_s2.latch;
		stat_w = dec_s2.stat;
		if (dec_s2.tcp) begin
			have_w = 1'b0;
			latch_w = 1'b0;
			stat_w = ST_UNSET;
			if (!old_final) begin
				unique case (dec_s2.kind)
					KIND_SYN: begin
						if (dec_s2.flags[0] && dec_s2.flags[1]) begin
							have_w = 1'b1;
							latch_w = 1'b1;
							stat_w = ST_OPEN;
						end else if (dec_s2.flags[2]) begin
							have_w = 1'b1;
							stat_w = ST_CLOSED;
						end
					end
					KIND_FIN, KIND_NULL, KIND_XMAS: begin
						have_w = 1'b1;
						latch_w = dec_s2.flags[2];
						stat_w = dec_s2.flags[2] ? ST_CLOSED : ST_OPEN_OR_FILTERED;
					end
					KIND_ACK: begin
						have_w = 1'b1;
						latch_w = dec_s2.flags[2];
						stat_w = dec_s2.flags[2] ? ST_UNFILTERED : ST_FILTERED;
					end
					default: ;
				endcase
			end
		end
	end

	assign ttl_next = (latch_w && cfg_q.os_detect_enable && latched_q == 8'd0)
		? dec_s2.ttl : latched_q;

	always_ff @(posedge clk) begin
		if (take) begin
			pkt_s1.source_address <= source_address;
			pkt_s1.ip_protocol <= ip_protocol;
			pkt_s1.ip_ttl <= ip_ttl;
			pkt_s1.src_port <= src_port;
			pkt_s1.dst_port <= dst_port;
			pkt_s1.tcp_flags <= tcp_flags;
			pkt_s1.icmp_type <= icmp_type;
			pkt_s1.icmp_code <= icmp_code;
			pkt_s1.inner_protocol <= inner_protocol;
			pkt_s1.inner_src_port <= inner_src_port;
			pkt_s1.inner_dst_port <= inner_dst_port;
		end
		if (state_q == S_LOOK) begin
			dec_s2 <= dec;
			addr_s2 <= addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q <= KIND_NONE;
			slot_q <= '0;
			latched_q <= '0;
			done <= 1'b0;
			accepted <= 1'b0;
			wrote <= 1'b0;
			slot <= '0;
			port <= '0;
			new_status <= '0;
			captured_ttl <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (take)
						state_q <= S_LOOK;
				end
				S_LOOK: begin
					kind_q <= dec.kind;
					slot_q <= dec.slot;
					state_q <= S_WRITE;
				end
				S_WRITE: begin
					latched_q <= ttl_next;
					done <= 1'b1;
					accepted <= dec_s2.accepted;
					wrote <= have_w;
					slot <= slot_q;
					port <= have_w ? dec_s2.port[PORT_OUT_W-1:0] : '0;
					new_status <= have_w ? stat_w : ST_UNSET;
					captured_ttl <= ttl_next;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_done_after_write: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == S_WRITE))
		else $error("result strobe without a write cycle");

	a_wrote_needs_match: assert property (@(posedge clk) disable iff (!arst_n)
		(done && wrote) |-> accepted)
		else $error("table written for a foreign source");

	a_idle_result_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !wrote) |-> (port == '0 && new_status == ST_UNSET))
		else $error("port or status reported without a write");

	a_ttl_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(latched_q != 8'd0) |=> $stable(latched_q))
		else $error("latched ttl changed after capture");
`endif

endmodule

/* dv/psrc_reply_checker.sv */
`timescale 1ns / 100ps

module psrc_reply_checker
	import psrc_pkg::*;
#(
	parameter int MAX_PORTS = MAX_PORTS_DEF,
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic [CFG_IDX_W-1:0] cfg_idx,
	input logic [CFG_DATA_W-1:0] cfg_wdata,
	input logic start,
	input logic busy,
	input pkt_t pkt,
	input logic done,
	input logic accepted,
	input logic wrote,
	input logic [2:0] slot,
	input logic [PORT_OUT_W-1:0] port,
	input logic [2:0] new_status,
	input logic [7:0] captured_ttl,
	output int replies_pending,
	output int mismatches
);

	typedef struct packed {
		logic accepted;
		logic wrote;
		logic [2:0] slot;
		logic [PORT_OUT_W-1:0] port;
		status_t status;
		logic [7:0] ttl;
	} reply_outcome_t;

	status_t port_state [NUM_SLOTS*MAX_PORTS];
	kind_t cur_kind;
	logic [2:0] cur_slot;
	logic [7:0] ttl_latch;
	cfg_t shadow;
	reply_outcome_t expected_replies [$];

	function automatic void pick_slot(kind_t k);
		logic [2:0] s;
		if (k == KIND_NONE || k > KIND_UDP)
			return;
		s = shadow.slot_map[3*(int'(k)-1) +: 3];
		// unmapped kinds keep the previous slot
		if (s < NUM_SLOTS)
			cur_slot = s;
	endfunction

	function automatic void lookup_kind(logic [15:0] p);
		logic [15:0] probe;
		// first match wins when offsets collide
		for (int k = int'(KIND_SYN); k <= int'(KIND_XMAS); k++) begin
			probe = shadow.probe_port_base + shadow.kind_codes[8*(k-1) +: 8];
			if (p == probe) begin
				cur_kind = kind_t'(k);
				pick_slot(cur_kind);
				return;
			end
		end
	endfunction

	function automatic void latch_ttl(logic [7:0] ttl);
		if (shadow.os_detect_enable && ttl_latch == 8'd0)
			ttl_latch = ttl;
	endfunction

	function automatic logic port_in_range(logic [15:0] p);
		return p != 16'd0 && int'(p) <= MAX_PORTS;
	endfunction

	function automatic int entry_of(logic [15:0] p);
		return int'(cur_slot) * MAX_PORTS + int'(p) - 1;
	endfunction

	function automatic logic unreach_filtered(logic [7:0] code);
		return code == UNR_HOST || code == UNR_PROTO || code == UNR_NET_PROHIB ||
			code == UNR_HOST_PROHIB || code == UNR_ADMIN_PROHIB;
	endfunction

	function automatic reply_outcome_t classify_reply(pkt_t p);
		reply_outcome_t r;
		status_t stat;
		status_t prior;
		logic [15:0] wport;
		logic have;
		logic syn;
		logic ack;
		logic rst;
		r = '0;
		stat = ST_UNSET;
		wport = '0;
		have = 1'b0;
		syn = p.tcp_flags[0];
		ack = p.tcp_flags[1];
		rst = p.tcp_flags[2];
		if (p.source_address == shadow.target_address) begin
			r.accepted = 1'b1;
			case (p.ip_protocol)
				PROTO_ICMP: begin
					if (p.inner_protocol == PROTO_TCP) begin
						lookup_kind(p.inner_src_port);
						if (p.icmp_type == ICMP_UNREACH &&
								(p.icmp_code == UNR_PORT || unreach_filtered(p.icmp_code))) begin
							wport = p.inner_dst_port;
							stat = ST_FILTERED;
							have = 1'b1;
						end
					end else begin
						cur_kind = KIND_UDP;
						pick_slot(KIND_UDP);
						if (p.icmp_type == ICMP_UNREACH) begin
							if (p.icmp_code == UNR_PORT) begin
								wport = p.inner_dst_port;
								stat = ST_CLOSED;
								have = 1'b1;
							end else if (unreach_filtered(p.icmp_code)) begin
								wport = p.inner_dst_port;
								stat = ST_FILTERED;
								have = 1'b1;
							end
						end
					end
					if (have && !port_in_range(wport))
						have = 1'b0;
				end
				PROTO_TCP: begin
					if (port_in_range(p.src_port)) begin
						lookup_kind(p.dst_port);
						prior = port_state[entry_of(p.src_port)];
						// open, closed and unfiltered are final for tcp replies
						if (prior != ST_OPEN && prior != ST_CLOSED && prior != ST_UNFILTERED) begin
							wport = p.src_port;
							case (cur_kind)
								KIND_SYN: begin
									if (syn && ack) begin
										latch_ttl(p.ip_ttl);
										stat = ST_OPEN;
										have = 1'b1;
									end else if (rst) begin
										stat = ST_CLOSED;
										have = 1'b1;
									end
								end
								KIND_FIN, KIND_NULL, KIND_XMAS: begin
									if (rst) begin
										latch_ttl(p.ip_ttl);
										stat = ST_CLOSED;
									end else begin
										stat = ST_OPEN_OR_FILTERED;
									end
									have = 1'b1;
								end
								KIND_ACK: begin
									if (rst) begin
										latch_ttl(p.ip_ttl);
										stat = ST_UNFILTERED;
									end else begin
										stat = ST_FILTERED;
									end
									have = 1'b1;
								end
								default: ;
							endcase
						end
					end
				end
				PROTO_UDP: begin
					cur_kind = KIND_UDP;
					pick_slot(KIND_UDP);
					if (port_in_range(p.src_port)) begin
						latch_ttl(p.ip_ttl);
						wport = p.src_port;
						stat = ST_OPEN;
						have = 1'b1;
					end
				end
				default: ;
			endcase
			if (have) begin
				port_state[entry_of(wport)] = stat;
				r.wrote = 1'b1;
				r.port = wport[PORT_OUT_W-1:0];
				r.status = stat;
			end
		end
		r.slot = cur_slot;
		r.ttl = ttl_latch;
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reply_outcome_t want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS*MAX_PORTS; i++)
				port_state[i] = ST_UNSET;
			cur_kind = KIND_NONE;
			cur_slot = '0;
			ttl_latch = '0;
			shadow.target_address = '0;
			shadow.os_detect_enable = 1'b0;
			shadow.probe_port_base = PORT_BASE_RST;
			shadow.kind_codes = KIND_CODES_RST;
			shadow.slot_map = SLOT_MAP_RST;
			expected_replies.delete();
			mismatches = 0;
			replies_pending <= 0;
		end else begin
			if (done) begin
				if (expected_replies.size() == 0) begin
					$display("%0t: result with no packet outstanding, got port %0d", $time, port);
					mismatches++;
				end else begin
					want = expected_replies.pop_front();
					check_field("accepted", want.accepted, accepted);
					check_field("wrote", want.wrote, wrote);
					check_field("slot", want.slot, slot);
					check_field("port", want.port, port);
					check_field("new_status", want.status, new_status);
					check_field("captured_ttl", want.ttl, captured_ttl);
				end
			end
			if (cfg_wr_en) begin
				case (cfg_idx)
					REG_TARGET_ADDR: shadow.target_address = cfg_wdata[31:0];
					REG_OS_DETECT: shadow.os_detect_enable = cfg_wdata[0];
					REG_PORT_BASE: shadow.probe_port_base = cfg_wdata[15:0];
					REG_KIND_CODES: shadow.kind_codes = cfg_wdata[39:0];
					REG_SLOT_MAP: shadow.slot_map = cfg_wdata[17:0];
					default: ;
				endcase
			end
			if (start && !busy)
				expected_replies.push_back(classify_reply(pkt));
			replies_pending <= expected_replies.size();
		end
	end

endmodule

/* dv/tb_port_scan_response_classifier_core.sv */
`timescale 1ns / 100ps

module tb_port_scan_response_classifier_core;
	import psrc_pkg::*;

	localparam int NUM_PHASES = 6;
	localparam int PER_PHASE = 160;
	localparam int LIMIT_CYCLES = 200000;

	localparam logic [2:0] FL_SYN = 3'b001;
	localparam logic [2:0] FL_ACK = 3'b010;
	localparam logic [2:0] FL_RST = 3'b100;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic start;
	logic busy;
	pkt_t pkt_q;
	logic done;
	logic accepted;
	logic wrote;
	logic [2:0] slot;
	logic [PORT_OUT_W-1:0] port;
	logic [2:0] new_status;
	logic [7:0] captured_ttl;
	int replies_pending;
	int mismatches;
	int cycles = 0;

	cfg_t regs;
	int burst_left;
	logic no_gaps;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	port_scan_response_classifier_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata),
		.start(start),
		.busy(busy),
		.source_address(pkt_q.source_address),
		.ip_protocol(pkt_q.ip_protocol),
		.ip_ttl(pkt_q.ip_ttl),
		.src_port(pkt_q.src_port),
		.dst_port(pkt_q.dst_port),
		.tcp_flags(pkt_q.tcp_flags),
		.icmp_type(pkt_q.icmp_type),
		.icmp_code(pkt_q.icmp_code),
		.inner_protocol(pkt_q.inner_protocol),
		.inner_src_port(pkt_q.inner_src_port),
		.inner_dst_port(pkt_q.inner_dst_port),
		.done(done),
		.accepted(accepted),
		.wrote(wrote),
		.slot(slot),
		.port(port),
		.new_status(new_status),
		.captured_ttl(captured_ttl)
	);

	psrc_reply_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata),
		.start(start),
		.busy(busy),
		.pkt(pkt_q),
		.done(done),
		.accepted(accepted),
		.wrote(wrote),
		.slot(slot),
		.port(port),
		.new_status(new_status),
		.captured_ttl(captured_ttl),
		.replies_pending(replies_pending),
		.mismatches(mismatches)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT_CYCLES) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic pkt_t blank_reply();
		pkt_t p;
		p.source_address = regs.target_address;
		p.ip_protocol = 8'($urandom);
		p.ip_ttl = 8'($urandom);
		p.src_port = 16'($urandom);
		p.dst_port = 16'($urandom);
		p.tcp_flags = 3'($urandom);
		p.icmp_type = 8'($urandom);
		p.icmp_code = 8'($urandom);
		p.inner_protocol = 8'($urandom);
		p.inner_src_port = 16'($urandom);
		p.inner_dst_port = 16'($urandom);
		return p;
	endfunction

	function automatic pkt_t tcp_reply(logic [15:0] sport, logic [15:0] dport,
			logic [2:0] flags, logic [7:0] ttl);
		pkt_t p;
		p = blank_reply();
		p.ip_protocol = PROTO_TCP;
		p.src_port = sport;
		p.dst_port = dport;
		p.tcp_flags = flags;
		p.ip_ttl = ttl;
		return p;
	endfunction

	function automatic pkt_t udp_reply(logic [15:0] sport, logic [7:0] ttl);
		pkt_t p;
		p = blank_reply();
		p.ip_protocol = PROTO_UDP;
		p.src_port = sport;
		p.ip_ttl = ttl;
		return p;
	endfunction

	function automatic pkt_t icmp_reply(logic [7:0] itype, logic [7:0] icode,
			logic [7:0] iproto, logic [15:0] isport, logic [15:0] idport);
		pkt_t p;
		p = blank_reply();
		p.ip_protocol = PROTO_ICMP;
		p.icmp_type = itype;
		p.icmp_code = icode;
		p.inner_protocol = iproto;
		p.inner_src_port = isport;
		p.inner_dst_port = idport;
		return p;
	endfunction

	function automatic logic [15:0] kind_port(kind_t k);
		return regs.probe_port_base + regs.kind_codes[8*(int'(k)-1) +: 8];
	endfunction

	// few low ports so repeated replies meet final states
	function automatic logic [15:0] any_port();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 16'($urandom_range(1, 16));
		if (r < 80)
			return 16'($urandom_range(1, MAX_PORTS_DEF));
		if (r < 88) begin
			case ($urandom_range(0, 3))
				0: return 16'd0;
				1: return 16'(MAX_PORTS_DEF);
				2: return 16'(MAX_PORTS_DEF + 1);
				default: return 16'hFFFF;
			endcase
		end
		return 16'($urandom);
	endfunction

	function automatic logic [15:0] probe_or_junk();
		if ($urandom_range(0, 99) < 85)
			return kind_port(kind_t'($urandom_range(int'(KIND_SYN), int'(KIND_XMAS))));
		return 16'($urandom);
	endfunction

	task automatic drain_replies();
		start <= 1'b0;
		do @(posedge clk); while (replies_pending != 0);
		repeat (4) @(posedge clk);
	endtask

	// one transfer, then burst and gap pacing
	task automatic drive_reply(pkt_t p);
		int gap;
		start <= 1'b1;
		pkt_q <= p;
		do @(posedge clk); while (busy);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = no_gaps ? 0 : $urandom_range(0, 9);
			if (gap > 0) begin
				start <= 1'b0;
				pkt_q <= blank_reply();
				repeat (gap) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
		if ($urandom_range(0, 79) == 0)
			drain_replies();
	endtask

	initial begin
		cfg_t c;
		cfg_reg_t r;
		pkt_t p;
		int hits;
		int pick;
		logic [7:0] itype;
		logic [7:0] icode;
		logic [7:0] iproto;
		arst_n <= 1'b0;
		start <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_idx <= REG_TARGET_ADDR;
		cfg_wdata <= '0;
		pkt_q <= '0;
		burst_left = 0;
		no_gaps = 1'b0;
		regs = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph > 0)
				drain_replies();
			c.target_address = $urandom;
			c.os_detect_enable = 1'b1;
			c.probe_port_base = 16'($urandom);
			c.kind_codes = {8'($urandom), 32'($urandom)};
			c.slot_map = 18'($urandom);
			case (ph)
				0: begin
					c.probe_port_base = PORT_BASE_RST;
					c.kind_codes = KIND_CODES_RST;
					c.slot_map = 18'o543210;
				end
				1: begin
					// every offset equal, so the syn kind always wins
					c.target_address = '0;
					c.os_detect_enable = 1'b0;
					c.probe_port_base = '0;
					c.kind_codes = '1;
					c.slot_map = '0;
				end
				2: begin
					c.target_address = '1;
					c.probe_port_base = '1;
					c.slot_map = SLOT_MAP_RST;
				end
				4: begin
					c.os_detect_enable = 1'($urandom);
					c.probe_port_base = 16'hFFFC;
					c.kind_codes = '0;
					c.slot_map = 18'o012345;
				end
				default: ;
			endcase
			r = r.first();
			do begin
				cfg_wr_en <= 1'b1;
				cfg_idx <= r;
				case (r)
					REG_TARGET_ADDR: cfg_wdata <= 40'(c.target_address);
					REG_OS_DETECT: cfg_wdata <= 40'(c.os_detect_enable);
					REG_PORT_BASE: cfg_wdata <= 40'(c.probe_port_base);
					REG_KIND_CODES: cfg_wdata <= c.kind_codes;
					default: cfg_wdata <= 40'(c.slot_map);
				endcase
				@(posedge clk);
				r = r.next();
			end while (r != r.first());
			cfg_wr_en <= 1'b0;
			regs = c;
			no_gaps = (ph == 2);

			if (ph == 0) begin
				p = tcp_reply(16'd1, kind_port(KIND_SYN), FL_SYN | FL_ACK, 8'd9);
				p.source_address = regs.target_address ^ 32'h8000_0001;
				drive_reply(p);
				// zero ttl leaves the latch free
				drive_reply(tcp_reply(16'd1, kind_port(KIND_SYN), FL_SYN | FL_ACK, 8'd0));
				drive_reply(tcp_reply(16'd1, kind_port(KIND_SYN), FL_RST, 8'd33));
				drive_reply(tcp_reply(16'd1024, kind_port(KIND_SYN), FL_SYN | FL_ACK, 8'd64));
				drive_reply(tcp_reply(16'd0, kind_port(KIND_ACK), FL_RST, 8'd70));
				drive_reply(tcp_reply(16'd1025, kind_port(KIND_ACK), FL_RST, 8'd70));
				drive_reply(tcp_reply(16'd2, kind_port(KIND_SYN) + 16'd200, 3'b000, 8'd1));
				drive_reply(tcp_reply(16'd5, kind_port(KIND_ACK), FL_RST, 8'd80));
				drive_reply(tcp_reply(16'd6, kind_port(KIND_ACK), 3'b000, 8'd80));
				drive_reply(tcp_reply(16'd7, kind_port(KIND_FIN), FL_RST | FL_SYN | FL_ACK,
					8'd255));
				drive_reply(tcp_reply(16'd8, kind_port(KIND_NULL), 3'b000, 8'd255));
				drive_reply(tcp_reply(16'd8, kind_port(KIND_XMAS), FL_RST, 8'd200));
				drive_reply(udp_reply(16'd9, 8'd128));
				drive_reply(udp_reply(16'd0, 8'd128));
				// kind is now udp, so a tcp reply writes nothing
				drive_reply(tcp_reply(16'd10, kind_port(KIND_SYN) + 16'd200, FL_RST, 8'd5));
				drive_reply(icmp_reply(ICMP_UNREACH, UNR_ADMIN_PROHIB, PROTO_TCP,
					kind_port(KIND_SYN), 16'd10));
				drive_reply(icmp_reply(ICMP_UNREACH, 8'd0, PROTO_TCP, kind_port(KIND_FIN), 16'd11));
				drive_reply(icmp_reply(ICMP_UNREACH, UNR_PORT, PROTO_UDP, 16'hFFFF, 16'd1));
				drive_reply(icmp_reply(ICMP_UNREACH, UNR_NET_PROHIB, PROTO_UDP, 16'd0, 16'd1024));
				drive_reply(icmp_reply(8'd11, UNR_PORT, PROTO_UDP, 16'd0, 16'd2));
				drive_reply(icmp_reply(ICMP_UNREACH, UNR_HOST, PROTO_TCP, kind_port(KIND_ACK),
					16'd0));
				drive_reply(icmp_reply(ICMP_UNREACH, UNR_PROTO, PROTO_TCP, kind_port(KIND_ACK),
					16'd5));
				drive_reply(icmp_reply(ICMP_UNREACH, UNR_HOST_PROHIB, 8'd50, 16'd0, 16'd1025));
				p = blank_reply();
				p.ip_protocol = 8'd50;
				drive_reply(p);
				drive_reply(tcp_reply(16'd5, kind_port(KIND_ACK), FL_RST, 8'd1));
			end

			hits = 0;
			while (hits < PER_PHASE) begin
				pick = $urandom_range(0, 99);
				if (pick < 45) begin
					p = tcp_reply(any_port(), probe_or_junk(), 3'($urandom), 8'($urandom));
				end else if (pick < 65) begin
					p = udp_reply(any_port(), 8'($urandom));
				end else if (pick < 93) begin
					itype = ($urandom_range(0, 4) == 0) ? 8'($urandom) : ICMP_UNREACH;
					icode = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
					case ($urandom_range(0, 4))
						0, 1, 2: iproto = PROTO_TCP;
						3: iproto = PROTO_UDP;
						default: iproto = 8'($urandom);
					endcase
					p = icmp_reply(itype, icode, iproto, probe_or_junk(), any_port());
				end else begin
					p = blank_reply();
				end
				if ($urandom_range(0, 9) == 0) begin
					if ($urandom_range(0, 1) == 1)
						p.source_address = regs.target_address ^ (32'd1 << $urandom_range(0, 31));
					else
						p.source_address = $urandom;
				end
				if (p.source_address == regs.target_address)
					hits++;
				drive_reply(p);
			end
		end

		drain_replies();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

/* files.f */
hw/rtl/psrc_pkg.sv
hw/rtl/psrc_decode.sv
hw/rtl/psrc_status_mem.sv
hw/rtl/port_scan_response_classifier_core.sv
dv/psrc_reply_checker.sv
dv/tb_port_scan_response_classifier_core.sv
